[hw/rtl/bivc_pkg.sv]
// shared types and constants for the boot image validator
`timescale 1ns / 1ps
`default_nettype none

package bivc_pkg;

    // header signature and control byte
    localparam logic [7:0] SIG_FIRST     = 8'h43;
    localparam logic [7:0] SIG_SECOND    = 8'h59;
    localparam logic [7:0] CTRL_NOT_EXEC = 8'h01;

    // register reset values
    localparam logic [10:0] MAX_SECTIONS_RESET  = 11'd1024;
    localparam logic [7:0]  EXPECTED_TYPE_RESET = 8'hB0;

    // smallest image that is not reported as short
    localparam int MIN_IMAGE_BYTES = 16;

    // result queue depth and stream data width
    localparam int FIFO_DEPTH = 4;
    localparam int TDATA_W    = 176;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_LENGTH   = 3'd1,
        PH_ADDRESS  = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_CHECKSUM = 3'd4,
        PH_DONE     = 3'd5,
        PH_HALT     = 3'd6
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_SIGNATURE = 4'd2,
        ST_NOT_EXEC  = 4'd3,
        ST_TYPE      = 4'd4,
        ST_TRUNCATED = 4'd5,
        ST_LAYOUT    = 4'd6,
        ST_CHECKSUM  = 4'd7,
        ST_EMPTY     = 4'd8
    } status_t;

    typedef enum logic {
        KIND_SECTION = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef enum logic {
        CFG_MAX_SECTIONS  = 1'b0,
        CFG_EXPECTED_TYPE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] section_address;
        logic [31:0] payload_offset;
        logic [31:0] section_words;
        status_t     status;
        logic [31:0] entry_point;
        logic [10:0] section_count;
        logic [31:0] payload_total;
        logic        run_end;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/boot_image_validator_core.sv]
// boot image validator top level: input stage, parser, result queue
// an accepted byte is registered in the input stage and parsed once the result queue
// has room; its results are written into the queue and from there show on the master side
// throughput: one byte per cycle when the queue has room; up to two records/cycle
// a byte that ends both a section header and the image pushes two records
// reset: all image state clears at once, registers return to 1024 and 0xB0
`timescale 1ns / 1ps
`default_nettype none

module boot_image_validator_core #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // slave side, tdata: data_byte
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    // master side, tdata: section_address, payload_offset, section_words,
    // status, entry point, section_count, payload_total, zero pad
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [bivc_pkg::TDATA_W-1:0]       m_axis_tdata,
    output logic                               m_axis_tuser,   // result_kind
    output logic                               m_axis_tlast,   // run_end
    // register write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [10:0]                   cfg_data
);
    import bivc_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic [10:0] max_sections_reg;
    logic [7:0]  expected_type_reg;
    logic        s_fire;
    logic        proc_fire;
    logic        room;
    logic [1:0]  push_count;
    result_t     rec0;
    result_t     rec1;
    result_t     head;

    // input stage handshake
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign proc_fire     = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign in_valid_next = s_fire ? 1'b1 : (proc_fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sections_reg  <= MAX_SECTIONS_RESET;
            expected_type_reg <= EXPECTED_TYPE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAX_SECTIONS:  max_sections_reg  <= cfg_data;
                CFG_EXPECTED_TYPE: expected_type_reg <= cfg_data[7:0];
                default:           max_sections_reg  <= max_sections_reg;
            endcase
        end
    end

    bivc_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (proc_fire),
        .in_byte       (in_byte_reg),
        .in_last       (in_last_reg),
        .max_sections  (max_sections_reg),
        .expected_type (expected_type_reg),
        .push_count    (push_count),
        .rec0          (rec0),
        .rec1          (rec1)
    );

    bivc_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data0 (rec0),
        .push_data1 (rec1),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (head)
    );

    // output beat packing
    assign m_axis_tdata = {1'b0, head.payload_total, head.section_count,
                           head.entry_point, head.status, head.section_words,
                           head.payload_offset, head.section_address};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.run_end;

endmodule

`default_nettype wire

[hw/rtl/bivc_parser.sv]
// image parser: per-byte state update and result records
`timescale 1ns / 1ps
`default_nettype none

module bivc_parser #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    input  wire logic [10:0]       max_sections,
    input  wire logic [7:0]        expected_type,
    output logic [1:0]             push_count,
    output bivc_pkg::result_t      rec0,
    output bivc_pkg::result_t      rec1
);
    import bivc_pkg::*;

    localparam int PW = POSITION_BITS;

    // image state
    phase_t      phase_reg, phase_step, phase_next;
    logic [1:0]  idx_reg, idx_step, idx_next;
    logic [31:0] shift_reg, shift_step, shift_next;
    logic [31:0] words_reg, words_step, words_next;
    logic [31:0] held_reg, held_step, held_next;
    logic [31:0] running_reg, running_step, running_next;
    logic [10:0] sections_reg, sections_step, sections_next;
    logic [PW-1:0] pos_reg, pos_next;
    status_t     err_reg, err_step, err_next;
    logic [31:0] psum_reg, psum_step, psum_next;
    logic [31:0] entry_reg, entry_step, entry_next;

    logic          sec_emit;
    logic [PW-1:0] pos_sat;
    logic [31:0]   offset_w;
    logic [31:0]   byte_placed;
    logic [31:0]   word_full;
    logic          word_done;
    logic [34:0]   psum_wide;
    status_t       verdict;
    result_t       rec_sec;
    result_t       rec_ver;

    // saturating byte position
    assign pos_sat = (&pos_reg) ? pos_reg : pos_reg + 1'b1;

    if (PW >= 32) begin : g_off_wide
        assign offset_w = pos_sat[31:0];
    end else begin : g_off_narrow
        assign offset_w = {{(32 - PW){1'b0}}, pos_sat};
    end

    // little-endian word assembly
    assign byte_placed = 32'(in_byte) << {idx_reg, 3'b000};
    assign word_full   = shift_reg | byte_placed;
    assign word_done   = (idx_reg == 2'd3);
    assign psum_wide   = {3'b000, psum_reg} + {1'b0, words_reg, 2'b00};

    // next state for one byte
    always_comb
    begin
        phase_step    = phase_reg;
        idx_step      = idx_reg;
        shift_step    = shift_reg;
        words_step    = words_reg;
        held_step     = held_reg;
        running_step  = running_reg;
        sections_step = sections_reg;
        err_step      = err_reg;
        psum_step     = psum_reg;
        entry_step    = entry_reg;
        sec_emit      = 1'b0;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg == PW'(0) && in_byte != SIG_FIRST)
                begin
                    err_step   = (err_reg == ST_OK) ? ST_SIGNATURE : err_reg;
                    phase_step = PH_HALT;
                end
                else if (pos_reg == PW'(1) && in_byte != SIG_SECOND)
                begin
                    err_step   = (err_reg == ST_OK) ? ST_SIGNATURE : err_reg;
                    phase_step = PH_HALT;
                end
                else if (pos_reg == PW'(2) && (in_byte & CTRL_NOT_EXEC) != 8'h00)
                begin
                    err_step   = (err_reg == ST_OK) ? ST_NOT_EXEC : err_reg;
                    phase_step = PH_HALT;
                end
                else if (pos_reg == PW'(3))
                begin
                    if (in_byte != expected_type)
                    begin
                        err_step   = (err_reg == ST_OK) ? ST_TYPE : err_reg;
                        phase_step = PH_HALT;
                    end
                    else
                    begin
                        phase_step = PH_LENGTH;
                        idx_step   = 2'd0;
                        shift_step = 32'd0;
                    end
                end
            end
            PH_LENGTH:
            begin
                idx_step   = idx_reg + 2'd1;
                shift_step = word_full;
                if (word_done)
                begin
                    words_step = word_full;
                    shift_step = 32'd0;
                    phase_step = PH_ADDRESS;
                end
            end
            PH_ADDRESS:
            begin
                idx_step   = idx_reg + 2'd1;
                shift_step = word_full;
                if (word_done)
                begin
                    held_step  = word_full;
                    shift_step = 32'd0;
                    if (words_reg == 32'd0)
                    begin
                        entry_step = word_full;
                        phase_step = PH_CHECKSUM;
                    end
                    else if (sections_reg >= max_sections)
                    begin
                        err_step   = (err_reg == ST_OK) ? ST_LAYOUT : err_reg;
                        phase_step = PH_HALT;
                    end
                    else
                    begin
                        sections_step = sections_reg + 11'd1;
                        psum_step     = (psum_wide[34:32] != 3'b000) ? 32'hFFFF_FFFF
                                                                     : psum_wide[31:0];
                        sec_emit      = 1'b1;
                        phase_step    = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                idx_step   = idx_reg + 2'd1;
                shift_step = word_full;
                if (word_done)
                begin
                    running_step = running_reg + word_full;
                    shift_step   = 32'd0;
                    words_step   = words_reg - 32'd1;
                    if (words_reg == 32'd1)
                    begin
                        phase_step = PH_LENGTH;
                    end
                end
            end
            PH_CHECKSUM:
            begin
                idx_step   = idx_reg + 2'd1;
                shift_step = word_full;
                if (word_done)
                begin
                    held_step  = word_full;
                    shift_step = 32'd0;
                    phase_step = PH_DONE;
                end
            end
            PH_DONE:
            begin
                err_step   = (err_reg == ST_OK) ? ST_LAYOUT : err_reg;
                phase_step = PH_HALT;
            end
            default:
            begin
                phase_step = phase_reg;
            end
        endcase
    end

    // the final byte returns the image state to reset
    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        shift_next    = shift_reg;
        words_next    = words_reg;
        held_next     = held_reg;
        running_next  = running_reg;
        sections_next = sections_reg;
        pos_next      = pos_reg;
        err_next      = err_reg;
        psum_next     = psum_reg;
        entry_next    = entry_reg;
        if (in_fire)
        begin
            if (in_last)
            begin
                phase_next    = PH_HEADER;
                idx_next      = 2'd0;
                shift_next    = 32'd0;
                words_next    = 32'd0;
                held_next     = 32'd0;
                running_next  = 32'd0;
                sections_next = 11'd0;
                pos_next      = '0;
                err_next      = ST_OK;
                psum_next     = 32'd0;
                entry_next    = 32'd0;
            end
            else
            begin
                phase_next    = phase_step;
                idx_next      = idx_step;
                shift_next    = shift_step;
                words_next    = words_step;
                held_next     = held_step;
                running_next  = running_step;
                sections_next = sections_step;
                pos_next      = pos_sat;
                err_next      = err_step;
                psum_next     = psum_step;
                entry_next    = entry_step;
            end
        end
    end

    // verdict code, short image first
    always_comb
    begin
        priority if (pos_sat < PW'(MIN_IMAGE_BYTES))
            verdict = ST_SHORT;
        else if (err_step != ST_OK)
            verdict = err_step;
        else if (phase_step == PH_LENGTH || phase_step == PH_ADDRESS ||
                 phase_step == PH_PAYLOAD || phase_step == PH_HEADER)
            verdict = ST_TRUNCATED;
        else if (phase_step == PH_CHECKSUM)
            verdict = ST_LAYOUT;
        else if (held_step != running_step)
            verdict = ST_CHECKSUM;
        else if (sections_step == 11'd0)
            verdict = ST_EMPTY;
        else
            verdict = ST_OK;
    end

    // result records
    always_comb
    begin
        rec_sec.kind            = KIND_SECTION;
        rec_sec.section_address = word_full;
        rec_sec.payload_offset  = offset_w;
        rec_sec.section_words   = words_reg;
        rec_sec.status          = ST_OK;
        rec_sec.entry_point     = 32'd0;
        rec_sec.section_count   = sections_step;
        rec_sec.payload_total   = psum_step;
        rec_sec.run_end         = !in_last;

        rec_ver.kind            = KIND_VERDICT;
        rec_ver.section_address = 32'd0;
        rec_ver.payload_offset  = 32'd0;
        rec_ver.section_words   = 32'd0;
        rec_ver.status          = verdict;
        rec_ver.entry_point     = entry_step;
        rec_ver.section_count   = sections_step;
        rec_ver.payload_total   = psum_step;
        rec_ver.run_end         = 1'b1;

        push_count = in_fire ? ({1'b0, sec_emit} + {1'b0, in_last}) : 2'd0;
        rec0       = sec_emit ? rec_sec : rec_ver;
        rec1       = rec_ver;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            idx_reg      <= 2'd0;
            shift_reg    <= 32'd0;
            words_reg    <= 32'd0;
            held_reg     <= 32'd0;
            running_reg  <= 32'd0;
            sections_reg <= 11'd0;
            pos_reg      <= '0;
            err_reg      <= ST_OK;
            psum_reg     <= 32'd0;
            entry_reg    <= 32'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            shift_reg    <= shift_next;
            words_reg    <= words_next;
            held_reg     <= held_next;
            running_reg  <= running_next;
            sections_reg <= sections_next;
            pos_reg      <= pos_next;
            err_reg      <= err_next;
            psum_reg     <= psum_next;
            entry_reg    <= entry_next;
        end
    end

    // a final byte leaves a clean image state
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_last |=> phase_reg == PH_HEADER && pos_reg == '0)
        else $error("image state not cleared after final byte");

    // two results only when a section record meets the final byte
    a_two_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        push_count == 2'd2 |-> in_fire && in_last)
        else $error("two results without final byte");

    // a recorded error always halts the walk
    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ST_OK |-> phase_reg == PH_HALT)
        else $error("error recorded outside halt phase");

endmodule

`default_nettype wire

[hw/rtl/bivc_result_fifo.sv]
// small result queue taking up to two records per cycle
`timescale 1ns / 1ps
`default_nettype none

module bivc_result_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        push_count,
    input  wire bivc_pkg::result_t push_data0,
    input  wire bivc_pkg::result_t push_data1,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bivc_pkg::result_t      out_data
);
    import bivc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [AW-1:0]   wptr_reg, wptr_next;
    logic [AW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    assign out_valid = (count_reg != CW'(0));
    assign out_data  = mem_reg[rptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= CW'(DEPTH - 2));

    // pointer and count update
    always_comb
    begin
        wptr_next  = wptr_reg + AW'(push_count);
        rptr_next  = rptr_reg + AW'(pop);
        count_next = count_reg + CW'(push_count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wptr_reg] <= push_data0;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wptr_reg + AW'(1)] <= push_data1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_count != 2'd0 |-> (32'(count_reg) + 32'(push_count)) <= 32'(DEPTH))
        else $error("result queue overflow");

    a_push_limit: assert property (@(posedge clk) disable iff (!rst_n)
        push_count != 2'd3)
        else $error("more than two records pushed");

endmodule

`default_nettype wire
